FILE: rtl/fpr_pkg.sv
`default_nettype none
package fpr_pkg;

   localparam int FRAMES     = 16;
   localparam int COUNT_BITS = 24;

   localparam int PAGE_W     = 20;
   localparam int FIU_W      = 5;
   localparam int TIME_W     = 16;
   localparam int FIDX_OUT_W = 4;
   localparam int OUT_W      = 24;
   localparam int FRAC_W     = 8;

   localparam int IDX_W      = $clog2(FRAMES);
   localparam int FCNT_W     = $clog2(FRAMES + 1);
   localparam int CNT_W      = COUNT_BITS;
   localparam int PROD_W     = CNT_W + TIME_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_W      = SUM_W + FRAC_W;
   localparam int STEP_W     = $clog2(OUT_W + 1);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = TIME_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES_IN_USE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEM_TIME      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAULT_TIME    = 2'd2;

   localparam logic [FIU_W-1:0]  FIU_RESET        = 5'd16;
   localparam logic [TIME_W-1:0] MEM_TIME_RESET   = 16'd1;
   localparam logic [TIME_W-1:0] FAULT_TIME_RESET = 16'd100;

endpackage
`default_nettype wire

FILE: rtl/fifo_page_replacement_eat.sv
`default_nettype none
// FIFO page replacement unit. Each item is one page reference; the reply gives hit/miss,
// the frame that matched or was filled, the saturating miss and reference totals, and the
// effective access time in unsigned fixed point with 8 fractional bits, truncated. The unit
// works on one item at a time: it takes the item, searches the frames in use (at most 16)
// one by one up to the hit, or through all of them and then fills a frame on a miss, forms
// two products on the shared 24x16 multiplier, does one add, runs the restoring divider
// that produces the effective time and loads the reply once the previous reply is taken.
// A new item is taken while the previous reply still waits on rsp_stall. Frame valid bits
// clear at reset, so no clearing pass is needed. Registers may be written only while idle.
module fifo_page_replacement_eat import fpr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PAGE_W-1:0]     req_page_number,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [FIDX_OUT_W-1:0]      rsp_frame_index,
   output logic [OUT_W-1:0]           rsp_miss_total,
   output logic [OUT_W-1:0]           rsp_reference_total,
   output logic [OUT_W-1:0]           rsp_effective_time,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_MUL_A  = 3'd2;
   localparam logic [2:0] ST_MUL_B  = 3'd3;
   localparam logic [2:0] ST_ADD    = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   logic [2:0]            state_ff, state_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [FCNT_W-1:0]     n_ff, n_in;
   logic [FCNT_W-1:0]     search_ff, search_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]      miss_ff, miss_in;
   logic [CNT_W-1:0]      ref_ff, ref_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [OUT_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [FIDX_OUT_W-1:0] rsp_fidx_ff, rsp_fidx_in;
   logic [OUT_W-1:0]      rsp_miss_ff, rsp_miss_in;
   logic [OUT_W-1:0]      rsp_ref_ff, rsp_ref_in;
   logic [OUT_W-1:0]      rsp_eat_ff, rsp_eat_in;

   logic [FIU_W-1:0]      fiu_ff;
   logic [TIME_W-1:0]     mem_time_ff;
   logic [TIME_W-1:0]     fault_time_ff;

   logic [PAGE_W-1:0]     frame_pages_ff [FRAMES];
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_addr;

   logic [IDX_W-1:0]      scan_idx;
   logic [IDX_W-1:0]      miss_slot;
   logic [FCNT_W-1:0]     slot_next;
   logic [CNT_W-1:0]      mul_a;
   logic [TIME_W-1:0]     mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic [SUM_W-1:0]      sum;
   logic [NUM_W-1:0]      num;
   logic [CNT_W:0]        trial;
   logic                  trial_ge;
   logic                  req_acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign scan_idx  = search_ff[IDX_W-1:0];
   assign miss_slot = (FCNT_W'(ptr_ff) < n_ff) ? ptr_ff : '0;
   assign slot_next = FCNT_W'(miss_slot) + FCNT_W'(1);

   // shared multiplier: hit cost first, then fault cost
   assign mul_a = (state_ff == ST_MUL_A) ? (ref_ff - miss_ff) : miss_ff;
   assign mul_b = (state_ff == ST_MUL_A) ? mem_time_ff : fault_time_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign sum   = SUM_W'(acc_ff) + SUM_W'(prod_ff);
   assign num   = {sum, {FRAC_W{1'b0}}};

   // quotient always fits OUT_W bits, so the top of the dividend starts below refs
   assign trial    = {rem_ff, quo_ff[OUT_W-1]};
   assign trial_ge = (trial >= {1'b0, ref_ff});

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      n_in         = n_ff;
      search_in    = search_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      miss_in      = miss_ff;
      ref_in       = ref_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_ref_in   = rsp_ref_ff;
      rsp_eat_in   = rsp_eat_ff;
      mem_we       = 1'b0;
      mem_addr     = miss_slot;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               page_in   = req_page_number;
               search_in = '0;
               if (fiu_ff == '0) begin
                  n_in = FCNT_W'(1);
               end else if (int'(fiu_ff) > FRAMES) begin
                  n_in = FCNT_W'(FRAMES);
               end else begin
                  n_in = FCNT_W'(fiu_ff);
               end
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_ff == n_ff) begin
               hit_in             = 1'b0;
               slot_in            = miss_slot;
               mem_we             = 1'b1;
               valid_in[miss_slot] = 1'b1;
               ptr_in             = (slot_next < n_ff) ? IDX_W'(slot_next) : '0;
               if (miss_ff != CNT_MAX) begin
                  miss_in = miss_ff + CNT_W'(1);
               end
               if (ref_ff != CNT_MAX) begin
                  ref_in = ref_ff + CNT_W'(1);
               end
               state_in = ST_MUL_A;
            end else if (valid_ff[scan_idx] && frame_pages_ff[scan_idx] == page_ff) begin
               hit_in  = 1'b1;
               slot_in = scan_idx;
               if (ref_ff != CNT_MAX) begin
                  ref_in = ref_ff + CNT_W'(1);
               end
               state_in = ST_MUL_A;
            end else begin
               search_in = search_ff + FCNT_W'(1);
            end
         end
         ST_MUL_A: begin
            prod_in  = mul_p;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rem_in   = num[OUT_W +: CNT_W];
            quo_in   = num[OUT_W-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? CNT_W'(trial - {1'b0, ref_ff}) : trial[CNT_W-1:0];
            quo_in  = {quo_ff[OUT_W-2:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(OUT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_fidx_in  = FIDX_OUT_W'(slot_ff);
               rsp_miss_in  = OUT_W'(miss_ff);
               rsp_ref_in   = OUT_W'(ref_ff);
               rsp_eat_in   = quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         valid_ff      <= '0;
         miss_ff       <= '0;
         ref_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         fiu_ff        <= FIU_RESET;
         mem_time_ff   <= MEM_TIME_RESET;
         fault_time_ff <= FAULT_TIME_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         miss_ff      <= miss_in;
         ref_ff       <= ref_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_FRAMES_IN_USE: fiu_ff        <= csr_wdata[FIU_W-1:0];
               CSR_MEM_TIME:      mem_time_ff   <= csr_wdata;
               CSR_FAULT_TIME:    fault_time_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      n_ff        <= n_in;
      search_ff   <= search_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_fidx_ff <= rsp_fidx_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_ref_ff  <= rsp_ref_in;
      rsp_eat_ff  <= rsp_eat_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_pages_ff[mem_addr] <= page_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_frame_index     = rsp_fidx_ff;
   assign rsp_miss_total      = rsp_miss_ff;
   assign rsp_reference_total = rsp_ref_ff;
   assign rsp_effective_time  = rsp_eat_ff;

endmodule
`default_nettype wire

FILE: rtl/fpr_checker.sv
`default_nettype none
module fpr_checker import fpr_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [PAGE_W-1:0]     req_page_number,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_hit,
   input wire logic [FIDX_OUT_W-1:0] rsp_frame_index,
   input wire logic [OUT_W-1:0]      rsp_miss_total,
   input wire logic [OUT_W-1:0]      rsp_reference_total,
   input wire logic [OUT_W-1:0]      rsp_effective_time,
   input wire logic                  csr_we,
   input wire logic [CSR_ADDR_W-1:0] csr_addr,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // a reply waiting on stall stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("reply dropped while stalled");

   // one item at a time: the unit is busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // misses never outrun references
   a_miss_le_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_miss_total <= rsp_reference_total)
      else $error("miss total above reference total");

   // a new reply only appears after the unit has been busy with an item
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("reply without an item in work");

endmodule

bind fifo_page_replacement_eat fpr_checker u_fpr_checker (.*);
`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
   import fpr_pkg::*;

   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          SETTLE      = 60;
   localparam logic [63:0] CNT_MAX     = (64'd1 << CNT_W) - 64'd1;

   typedef struct packed {
      logic                  hit;
      logic [FIDX_OUT_W-1:0] frame_index;
      logic [OUT_W-1:0]      miss_total;
      logic [OUT_W-1:0]      reference_total;
      logic [OUT_W-1:0]      effective_time;
   } reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PAGE_W-1:0]     req_page_number = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_hit;
   logic [FIDX_OUT_W-1:0] rsp_frame_index;
   logic [OUT_W-1:0]      rsp_miss_total;
   logic [OUT_W-1:0]      rsp_reference_total;
   logic [OUT_W-1:0]      rsp_effective_time;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #4 clock = ~clock;

   fifo_page_replacement_eat u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_page_number     (req_page_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hit             (rsp_hit),
      .rsp_frame_index     (rsp_frame_index),
      .rsp_miss_total      (rsp_miss_total),
      .rsp_reference_total (rsp_reference_total),
      .rsp_effective_time  (rsp_effective_time),
      .csr_we              (csr_we),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata)
   );

   // shadow registers and frame table of the predictor
   logic [FIU_W-1:0]  fiu_q        = FIU_RESET;
   logic [TIME_W-1:0] mem_time_q   = MEM_TIME_RESET;
   logic [TIME_W-1:0] fault_time_q = FAULT_TIME_RESET;
   logic [PAGE_W-1:0] resident_pages [FRAMES];
   bit                resident_valid [FRAMES];
   int                fill_ptr = 0;
   logic [63:0]       miss_cnt = '0;
   logic [63:0]       ref_cnt  = '0;

   reply_t            expected_replies [$];
   logic [PAGE_W-1:0] page_queue [$];

   int req_presented = 0;
   int req_accepted  = 0;
   int rsp_accepted  = 0;
   int rsp_seen      = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   bit stall_drawn   = 1'b0;
   bit idle_on       = 1'b1;
   int errors        = 0;
   int cycles        = 0;

   function automatic int draw_wait();
      if (!idle_on || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return TIME_W'($urandom_range(0, 255));
         default: return TIME_W'($urandom);
      endcase
   endfunction

   task automatic lookup_page(input logic [PAGE_W-1:0] page);
      reply_t      r;
      int          n;
      int          slot;
      bit          found;
      logic [63:0] refs;
      logic [63:0] misses;
      logic [63:0] num;
      n = int'(fiu_q);
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!found && resident_valid[i] && resident_pages[i] == page) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         // pointer left past n after n was lowered: restart at frame 0
         slot = (fill_ptr < n) ? fill_ptr : 0;
         resident_pages[slot] = page;
         resident_valid[slot] = 1'b1;
         fill_ptr = (slot + 1 < n) ? slot + 1 : 0;
         if (miss_cnt < CNT_MAX) miss_cnt = miss_cnt + 64'd1;
      end
      if (ref_cnt < CNT_MAX) ref_cnt = ref_cnt + 64'd1;
      refs   = ref_cnt;
      misses = (miss_cnt > refs) ? refs : miss_cnt;
      num    = ((refs - misses) * 64'(mem_time_q) + misses * 64'(fault_time_q)) << FRAC_W;
      r.hit             = found;
      r.frame_index     = FIDX_OUT_W'(slot);
      r.miss_total      = miss_cnt[OUT_W-1:0];
      r.reference_total = ref_cnt[OUT_W-1:0];
      r.effective_time  = (refs != 64'd0) ? OUT_W'(num / refs) : '0;
      expected_replies.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_FRAMES_IN_USE: fiu_q        = data[FIU_W-1:0];
         CSR_MEM_TIME:      mem_time_q   = data[TIME_W-1:0];
         CSR_FAULT_TIME:    fault_time_q = data[TIME_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // block until every queued item is in and answered, then let it settle
   task automatic drain();
      while (page_queue.size() != 0 || req_presented != req_accepted ||
             expected_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : req_drv
      logic              v;
      logic [PAGE_W-1:0] p;
      v = req_valid;
      p = req_page_number;
      if (!reset && (!req_valid || req_accepted == req_presented)) begin
         v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (page_queue.size() > 0) begin
            p = page_queue.pop_front();
            v = 1'b1;
            req_presented++;
            gap_left = draw_wait();
         end
      end
      req_valid       <= v;
      req_page_number <= p;
   end

   // request side: predict on every accepted item
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         lookup_page(req_page_number);
         req_accepted <= req_accepted + 1;
      end
   end

   // reply back-pressure
   always @(negedge clock) begin : rsp_drv
      logic s;
      if (rsp_seen != rsp_accepted) begin
         rsp_seen    = rsp_accepted;
         stall_drawn = 1'b0;
      end
      if (rsp_valid === 1'b1 && !stall_drawn) begin
         stall_left  = draw_wait();
         stall_drawn = 1'b1;
      end
      if (stall_left > 0) begin
         s = 1'b1;
         stall_left--;
      end else if (rsp_valid === 1'b1) begin
         s = 1'b0;
      end else begin
         s = idle_on && ($urandom_range(0, 3) == 0);
      end
      rsp_stall <= s;
   end

   // reply checker
   always @(posedge clock) begin : rsp_mon
      reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_accepted <= rsp_accepted + 1;
         if (expected_replies.size() == 0) begin
            $error("reply item with none outstanding");
            errors++;
         end else begin
            want = expected_replies.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("frame_index", want.frame_index, rsp_frame_index);
            check_field("miss_total", want.miss_total, rsp_miss_total);
            check_field("reference_total", want.reference_total, rsp_reference_total);
            check_field("effective_time", want.effective_time, rsp_effective_time);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      logic [PAGE_W-1:0] pool [$];
      logic [CSR_DATA_W-1:0] wd;
      int fiu;
      int n_items;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: fill, hit both extreme pages, leave the pointer at 10
      page_queue = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555,
                     20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00005, 20'h00006,
                     20'h00003};
      drain();

      // shrink to 4 frames: pointer is past n, frames 4..15 are out of reach
      csr_write(CSR_FRAMES_IN_USE, 16'd4);
      csr_write(CSR_MEM_TIME, 16'hFFFF);
      csr_write(CSR_FAULT_TIME, 16'hFFFF);
      page_queue = '{20'h12345, 20'hFFFFF, 20'h00005};
      drain();

      // zero frames acts as one; zero costs
      csr_write(CSR_FRAMES_IN_USE, 16'd0);
      csr_write(CSR_MEM_TIME, 16'd0);
      csr_write(CSR_FAULT_TIME, 16'd0);
      page_queue = '{20'h00007, 20'h00007, 20'h00008};
      drain();

      // 31 acts as 16; old contents beyond the small window hit again
      csr_write(CSR_FRAMES_IN_USE, 16'd31);
      csr_write(CSR_MEM_TIME, MEM_TIME_RESET);
      csr_write(CSR_FAULT_TIME, FAULT_TIME_RESET);
      page_queue = '{20'h00003, 20'h55555, 20'h00009};
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 7))
            0:       fiu = 1;
            1:       fiu = 16;
            2:       fiu = 0;
            3:       fiu = $urandom_range(17, 31);
            default: fiu = $urandom_range(1, 16);
         endcase
         wd = CSR_DATA_W'($urandom);
         wd[FIU_W-1:0] = FIU_W'(fiu);
         if ($urandom_range(0, 1) == 0) wd[CSR_DATA_W-1:FIU_W] = '0;
         csr_write(CSR_FRAMES_IN_USE, wd);
         csr_write(CSR_MEM_TIME, pick_time());
         csr_write(CSR_FAULT_TIME, pick_time());
         idle_on = ($urandom_range(0, 3) != 0);

         // working set around the frame count so hits and evictions both occur
         pool.delete();
         repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 9))
               0:       pool.push_back('0);
               1:       pool.push_back('1);
               default: pool.push_back(PAGE_W'($urandom));
            endcase
         end
         n_items = $urandom_range(100, 175);
         for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 85)
               page_queue.push_back(pool[$urandom_range(0, pool.size() - 1)]);
            else
               page_queue.push_back(PAGE_W'($urandom));
         end
         drain();
      end

      if (expected_replies.size() != 0) begin
         $error("%0d reply items never arrived", expected_replies.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/fpr_pkg.sv
rtl/fifo_page_replacement_eat.sv
rtl/fpr_checker.sv
tb/tb_top.sv
